>>> sv/pfpd_pkg.sv
// Shared types, codes and helper functions of the parity-framed prefix-code decoder.
package pfpd_pkg;

  localparam int PFPD_TRIE_NODES = 1024;
  localparam int MAX_CODE_LEN    = 16;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_HEX   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_HEX  = 2'd1;
  localparam logic [1:0] ERR_PATH = 2'd2;
  localparam logic [1:0] ERR_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [7:0]  entry_symbol;
    logic [7:0]  hex_char;
  } cmd_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] error;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] symbol;
    logic [1:0] error;
  } push_t;

  typedef struct packed {
    logic no_child;
    logic table_full;
  } step_flags_t;

  // Returns {1, value} for an ASCII hex digit of either case, and zero otherwise.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, 4'(c - 8'h30)};
      [8'h41:8'h46]: r = {1'b1, 4'(c - 8'h37)};
      [8'h61:8'h66]: r = {1'b1, 4'(c - 8'h57)};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/pfpd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pfpd_step.sv
// Shared trie step unit: child selection, empty-link test, table-full test and link insertion.
module pfpd_step import pfpd_pkg::*; #(
  parameter int TRIE_NODES = PFPD_TRIE_NODES
) (
  input  logic [2*((TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1)+8:0] node_data,
  input  logic                                                   bit_in,
  input  logic [((TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1):0]     nodes_used,
  output logic [((TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1)-1:0]   child,
  output step_flags_t                                            flags,
  output logic [2*((TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1)+8:0] linked
);

  localparam int IW  = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
  localparam int EW  = 2 * IW + 9;
  localparam int NUW = IW + 1;

  logic [IW-1:0] lo;
  logic [IW-1:0] hi;
  logic [IW-1:0] fresh;

  assign lo    = node_data[IW-1:0];
  assign hi    = node_data[2*IW-1:IW];
  assign fresh = nodes_used[IW-1:0];
  assign child = bit_in ? hi : lo;

  assign flags.no_child   = (child == '0);
  assign flags.table_full = (nodes_used >= NUW'(TRIE_NODES));

  // The new node index goes into the link that the current bit selects.
  assign linked = bit_in ? {node_data[EW-1:2*IW], fresh, lo}
                         : {node_data[EW-1:IW], fresh};

endmodule

>>> sv/pfpd_outq.sv
// Result holding stage: keeps one result back so that the final one of an item carries last.
module pfpd_outq import pfpd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  finish,
  output logic  result_valid,
  output res_t  result
);

  logic       pend_valid;
  logic [7:0] pend_symbol;
  logic [1:0] pend_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (push.valid) begin
        if (pend_valid) begin
          result_valid <= 1'b1;
          result       <= '{symbol: pend_symbol, error: pend_error, last: 1'b0};
        end
        pend_valid  <= 1'b1;
        pend_symbol <= push.symbol;
        pend_error  <= push.error;
      end else if (finish && pend_valid) begin
        result_valid <= 1'b1;
        result       <= '{symbol: pend_symbol, error: pend_error, last: 1'b1};
        pend_valid   <= 1'b0;
      end
    end
  end

endmodule

>>> sv/parity_framed_prefix_code_decoder_unit.sv
// Top level of the parity-framed prefix-code decoder: sequencer, trie store and state.
//
//  Channel   Signals                        Transfer when
//  --------  -----------------------------  ------------------------------------------
//  command   start, busy, cmd               start high and busy low at a rising edge
//  result    result_valid, result           result_valid high (one cycle, no back-pressure)
//  config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high at a rising edge
//
// A clear, an unused kind or a zero-length load completes in the cycle of its transfer
// and leaves busy low. A code load reads every existing trie node on its path, the root
// included, through S_LRD, S_LLD and S_LST, and sets up every new node in S_LST without
// a read; it then ends in S_DONE.
// A hex character shifts its bits through S_SHIFT and walks the data bits of each passed
// frame through S_WRD, S_WEV and S_WFIN on the single read port of the trie RAM, whose
// read is registered. Reset is synchronous and needs no sweep of the trie RAM: a node
// count and a root flag mark what is valid. The receiver of results cannot stall the
// block.
module parity_framed_prefix_code_decoder_unit import pfpd_pkg::*; #(
  parameter int TRIE_NODES = PFPD_TRIE_NODES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        result_valid,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW  = (TRIE_NODES > 1) ? $clog2(TRIE_NODES) : 1;
  localparam int EW  = 2 * IW + 9;
  localparam int NUW = IW + 1;
  localparam int FIN = 2 * IW + 8;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LRD   = 9'b000000010,
    S_LLD   = 9'b000000100,
    S_LST   = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_WRD   = 9'b000100000,
    S_WEV   = 9'b001000000,
    S_WFIN  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t         state;

  // Decoder state that lives across items.
  logic [NUW-1:0] nodes_used;
  logic           root_valid;
  logic [8:0]     frame;
  logic [3:0]     fill;
  logic [IW-1:0]  cur;
  logic [15:0]    emitted;
  logic [15:0]    to_decode;

  // Per-item working registers.
  logic [IW-1:0]  node;
  logic [EW-1:0]  nd;
  logic [15:0]    lbits;
  logic [4:0]     lcnt;
  logic [7:0]     lsym;
  logic [3:0]     hx;
  logic [2:0]     hcnt;
  logic [7:0]     wf;
  logic [3:0]     wcnt;
  logic           rd_root;

  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic [IW-1:0]  mem_raddr;
  logic [EW-1:0]  mem_rdata;
  logic [EW-1:0]  rdata_eff;

  logic [EW-1:0]  step_data;
  logic           step_bit;
  logic [IW-1:0]  step_child;
  step_flags_t    step_flags;
  logic [EW-1:0]  step_linked;

  logic [3:0]     lidx;
  logic [4:0]     hexv;
  logic [4:0]     len_sat;
  logic           count_done;
  push_t          push;
  logic           finish;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign lidx       = 4'(lcnt - 5'd1);
  assign hexv       = hex_nibble(cmd.hex_char);
  assign len_sat    = (cmd.code_length > 5'(MAX_CODE_LEN)) ? 5'(MAX_CODE_LEN)
                                                            : cmd.code_length;
  assign count_done = (emitted >= to_decode);

  // The root is never written at allocation, so until its first write since the last
  // clear it reads as an empty node. Every other node is written during the load that
  // creates it, before any read can reach it.
  assign rdata_eff = (rd_root && !root_valid) ? '0 : mem_rdata;

  pfpd_ram #(
    .WIDTH (EW),
    .DEPTH (TRIE_NODES)
  ) u_trie (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pfpd_step #(
    .TRIE_NODES (TRIE_NODES)
  ) u_step (
    .node_data  (step_data),
    .bit_in     (step_bit),
    .nodes_used (nodes_used),
    .child      (step_child),
    .flags      (step_flags),
    .linked     (step_linked)
  );

  pfpd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .finish       (finish),
    .result_valid (result_valid),
    .result       (result)
  );

  // Memory addressing, the input of the shared step unit and the results pushed.
  always_comb begin
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = node;
    mem_wdata = nd;
    push      = '0;
    finish    = (state == S_DONE);
    step_data = (state == S_WEV) ? rdata_eff : nd;
    step_bit  = (state == S_WEV) ? wf[7] : lbits[lidx];
    case (state)
      S_IDLE: begin
        if (start && cmd.kind == KIND_HEX && !hexv[4]) begin
          push = '{valid: 1'b1, symbol: 8'd0, error: ERR_HEX};
        end
      end
      S_LRD: begin
        mem_raddr = node;
      end
      S_LST: begin
        if (lcnt == 5'd0) begin
          // End of the code: mark the node as a leaf and store its symbol.
          mem_we    = 1'b1;
          mem_wdata = {1'b1, lsym, nd[2*IW-1:0]};
        end else if (step_flags.no_child) begin
          mem_we = 1'b1;
          if (step_flags.table_full) begin
            // A fresh node must still reach the RAM as an empty node.
            mem_wdata = nd;
            push      = '{valid: 1'b1, symbol: 8'd0, error: ERR_FULL};
          end else begin
            mem_wdata = step_linked;
          end
        end
      end
      S_WRD: begin
        mem_raddr = cur;
      end
      S_WEV: begin
        mem_raddr = step_child;
        if (step_flags.no_child) begin
          push = '{valid: 1'b1, symbol: 8'd0, error: ERR_PATH};
        end
      end
      S_WFIN: begin
        if (rdata_eff[FIN]) begin
          push = '{valid: 1'b1, symbol: rdata_eff[2*IW+7:2*IW], error: ERR_OK};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= NUW'(1);
      root_valid <= 1'b0;
      frame      <= '0;
      fill       <= '0;
      cur        <= '0;
      emitted    <= '0;
      to_decode  <= '0;
      lcnt       <= '0;
      hcnt       <= '0;
      wcnt       <= '0;
      rd_root    <= 1'b0;
    end else begin
      rd_root <= (mem_raddr == '0);
      if (cfg_valid && cfg_ready) begin
        to_decode <= cfg_data;
      end
      if (mem_we && mem_waddr == '0) begin
        root_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.kind)
              KIND_LOAD: begin
                if (cmd.code_length != 5'd0) begin
                  lbits <= cmd.code_bits;
                  lcnt  <= len_sat;
                  lsym  <= cmd.entry_symbol;
                  node  <= '0;
                  state <= S_LRD;
                end
              end
              KIND_HEX: begin
                if (hexv[4]) begin
                  hx    <= hexv[3:0];
                  hcnt  <= 3'd4;
                  state <= S_SHIFT;
                end else begin
                  state <= S_DONE;
                end
              end
              KIND_CLEAR: begin
                nodes_used <= NUW'(1);
                root_valid <= 1'b0;
                frame      <= '0;
                fill       <= '0;
                cur        <= '0;
                emitted    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LRD: begin
          state <= S_LLD;
        end
        S_LLD: begin
          nd    <= rdata_eff;
          state <= S_LST;
        end
        S_LST: begin
          if (lcnt == 5'd0) begin
            state <= S_DONE;
          end else if (!step_flags.no_child) begin
            node  <= step_child;
            lcnt  <= lcnt - 5'd1;
            state <= S_LRD;
          end else if (step_flags.table_full) begin
            state <= S_DONE;
          end else begin
            // The new node is known to be empty, so the walk goes on without a read.
            node       <= nodes_used[IW-1:0];
            nodes_used <= nodes_used + NUW'(1);
            nd         <= '0;
            lcnt       <= lcnt - 5'd1;
          end
        end
        S_SHIFT: begin
          if (hcnt == 3'd0) begin
            state <= S_DONE;
          end else begin
            hx   <= {hx[2:0], 1'b0};
            hcnt <= hcnt - 3'd1;
            if (fill == 4'd8) begin
              frame <= '0;
              fill  <= '0;
              if (^{frame[7:0], hx[3]}) begin
                wf    <= frame[7:0];
                wcnt  <= 4'd8;
                state <= S_WRD;
              end
            end else begin
              frame <= {frame[7:0], hx[3]};
              fill  <= fill + 4'd1;
            end
          end
        end
        S_WRD: begin
          if (wcnt == 4'd0) begin
            state <= S_SHIFT;
          end else if (count_done) begin
            wf   <= {wf[6:0], 1'b0};
            wcnt <= wcnt - 4'd1;
          end else begin
            state <= S_WEV;
          end
        end
        S_WEV: begin
          wf   <= {wf[6:0], 1'b0};
          wcnt <= wcnt - 4'd1;
          if (step_flags.no_child) begin
            cur   <= '0;
            state <= S_WRD;
          end else begin
            cur   <= step_child;
            state <= S_WFIN;
          end
        end
        S_WFIN: begin
          if (rdata_eff[FIN]) begin
            emitted <= emitted + 16'd1;
            cur     <= '0;
          end
          state <= S_WRD;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/pfpd_chk.sv
// Port-level checker of the parity-framed prefix-code decoder and its bind statement.
module pfpd_chk import pfpd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input res_t        result
);

  a_err_sym_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.error != ERR_OK) |-> (result.symbol == 8'd0))
    else $error("error result carries a nonzero symbol");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("final result shown while still busy");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("non-final result shown while idle");

  a_single_err: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.error == ERR_HEX || result.error == ERR_FULL))
      |-> result.last)
    else $error("hex or table error is not the only result of its item");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command transfer");

endmodule

bind parity_framed_prefix_code_decoder_unit pfpd_chk u_pfpd_chk (.*);
